// ===== src/mpfb_pkg.sv =====
// Package for the page framebuffer draw engine: sizes, command codes,
// controller/datapath command and status structs, and the 5x7 font table.
// No dependencies.
package mpfb_pkg;

  localparam int ScreenWidth  = 128;
  localparam int ScreenHeight = 64;
  localparam int PageCount    = (ScreenHeight + 7) / 8;
  localparam int StoreBytes   = ScreenWidth * PageCount;
  localparam int AddrW        = $clog2(StoreBytes);
  localparam int XW           = $clog2(ScreenWidth);
  localparam int YW           = $clog2(ScreenHeight);

  typedef enum logic [2:0] {
    FUNC_PIXEL = 3'd0,
    FUNC_HLINE = 3'd1,
    FUNC_VLINE = 3'd2,
    FUNC_RECT  = 3'd3,
    FUNC_GLYPH = 3'd4,
    FUNC_CLEAR = 3'd5,
    FUNC_READ  = 3'd6
  } func_t;

  // One datapath command: pixel write, clear write or byte read (pixel coordinates already on screen).
  typedef struct packed {
    logic          dot_en;
    logic [XW-1:0] dot_x;
    logic [YW-1:0] dot_y;
    logic          dot_on;
    logic          clr_en;
    logic [AddrW-1:0] clr_addr;
    logic          rd_en;
    logic [AddrW-1:0] rd_addr;
  } dp_cmd_t;

  typedef struct packed {
    logic       busy;
    logic [7:0] rd_data;
  } dp_status_t;

  // Font column lookup; lowercase folds, unknown codes are blank.
  function automatic logic [7:0] font_col(input logic [7:0] c, input logic [2:0] col);
    logic [39:0] g;
    logic [7:0]  u;
    u = (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
    case (u)
      8'h30: g = 40'h3E51_4945_3E;  8'h31: g = 40'h0042_7F40_00;
      8'h32: g = 40'h4261_5149_46;  8'h33: g = 40'h2141_454B_31;
      8'h34: g = 40'h1814_127F_10;  8'h35: g = 40'h2745_4545_39;
      8'h36: g = 40'h3C4A_4949_30;  8'h37: g = 40'h0171_0905_03;
      8'h38: g = 40'h3649_4949_36;  8'h39: g = 40'h0649_4929_1E;
      8'h41: g = 40'h7E11_1111_7E;  8'h42: g = 40'h7F49_4949_36;
      8'h43: g = 40'h3E41_4141_22;  8'h44: g = 40'h7F41_4122_1C;
      8'h45: g = 40'h7F49_4949_41;  8'h46: g = 40'h7F09_0909_01;
      8'h47: g = 40'h3E41_4949_7A;  8'h48: g = 40'h7F08_0808_7F;
      8'h49: g = 40'h0041_7F41_00;  8'h4A: g = 40'h2040_413F_01;
      8'h4B: g = 40'h7F08_1422_41;  8'h4C: g = 40'h7F40_4040_40;
      8'h4D: g = 40'h7F02_0C02_7F;  8'h4E: g = 40'h7F04_0810_7F;
      8'h4F: g = 40'h3E41_4141_3E;  8'h50: g = 40'h7F09_0909_06;
      8'h51: g = 40'h3E41_5121_5E;  8'h52: g = 40'h7F09_1929_46;
      8'h53: g = 40'h2649_4949_32;  8'h54: g = 40'h0101_7F01_01;
      8'h55: g = 40'h3F40_4040_3F;  8'h56: g = 40'h1F20_4020_1F;
      8'h57: g = 40'h7F20_1820_7F;  8'h58: g = 40'h6314_0814_63;
      8'h59: g = 40'h0708_7008_07;  8'h5A: g = 40'h6151_4945_43;
      8'h2E: g = 40'h0060_6000_00;  8'h2D: g = 40'h0808_0808_08;
      8'h3A: g = 40'h0036_3600_00;  8'h2F: g = 40'h2010_0804_02;
      default: g = 40'h0;
    endcase
    case (col)
      3'd0: font_col = g[39:32];
      3'd1: font_col = g[31:24];
      3'd2: font_col = g[23:16];
      3'd3: font_col = g[15:8];
      3'd4: font_col = g[7:0];
      default: font_col = 8'h00;
    endcase
  endfunction

endpackage

// ===== src/mpfb_datapath.sv =====
// Datapath: frame store memory with read-modify-write of single pixels,
// clear sweep writes and byte read-back. Uses mpfb_pkg.
module mpfb_datapath (
  input  logic                clk,
  input  mpfb_pkg::dp_cmd_t   cmd,
  output mpfb_pkg::dp_status_t status
);
  import mpfb_pkg::*;

  logic [7:0] mem [StoreBytes];
  logic [7:0] rdata_r;
  logic       pend_r;
  logic [AddrW-1:0] waddr_r;
  logic [2:0] wbit_r;
  logic       won_r;
  logic [AddrW-1:0] dot_addr;
  logic [7:0] wdata;
  logic [7:0] bmask;

  assign dot_addr = AddrW'(cmd.dot_x) +
                    AddrW'(AddrW'(cmd.dot_y >> 3) * AddrW'(ScreenWidth));

  // Memory read port: pixel byte or read-back byte.
  always_ff @(posedge clk) begin
    if (cmd.dot_en) rdata_r <= mem[dot_addr];
    else if (cmd.rd_en) rdata_r <= mem[cmd.rd_addr];
  end

  // Pixel write: the byte read is registered, then the bit is merged and written back.
  always_ff @(posedge clk) begin
    pend_r  <= cmd.dot_en;
    waddr_r <= dot_addr;
    wbit_r  <= 3'(cmd.dot_y);
    won_r   <= cmd.dot_on;
  end

  assign bmask = 8'd1 << wbit_r;
  assign wdata = won_r ? (rdata_r | bmask) : (rdata_r & ~bmask);

  always_ff @(posedge clk) begin
    if (cmd.clr_en) mem[cmd.clr_addr] <= 8'h00;
    else if (pend_r) mem[waddr_r] <= wdata;
  end

  assign status.busy    = pend_r;
  assign status.rd_data = rdata_r;
endmodule

// ===== src/mpfb_ctrl.sv =====
// Controller: decodes commands into line segments and glyph walks, then
// issues one pixel write, clear write or byte read per step to the datapath. Uses mpfb_pkg.
module mpfb_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           in_func,
  input  logic signed [15:0]   in_x_a,
  input  logic signed [15:0]   in_y_a,
  input  logic signed [15:0]   in_x_b,
  input  logic signed [15:0]   in_y_b,
  input  logic                 in_color,
  input  logic [7:0]           in_char_code,
  input  logic [9:0]           in_read_addr,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_read_data,
  output mpfb_pkg::dp_cmd_t    cmd,
  input  mpfb_pkg::dp_status_t status
);
  import mpfb_pkg::*;

  typedef enum logic [7:0] {
    S_INIT  = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_SEG   = 8'b0000_0100,
    S_DRAW  = 8'b0000_1000,
    S_GLYPH = 8'b0001_0000,
    S_CLEAR = 8'b0010_0000,
    S_READ  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic [2:0]  func_r;
  logic signed [17:0] xa_r, ya_r, xb_r, yb_r;
  logic        on_r;
  logic [7:0]  code_r;
  logic [9:0]  raddr_r;
  logic [1:0]  seg_r, seg_nxt;
  logic        vert_r;
  logic signed [17:0] cur_r, end_r, fix_r;
  logic [AddrW-1:0] clr_r;
  logic [2:0]  gcol_r;
  logic [2:0]  grow_r;
  logic [7:0]  obuf_r;
  logic        ovld_r;
  logic        read_hit_r;

  // Segment setup for the current segment index (one compare set).
  logic signed [17:0] s_a, s_b, s_f, s_lo, s_hi, lim;
  logic        s_vert, s_ok;
  always_comb begin
    s_vert = 1'b0; s_a = xa_r; s_b = xb_r; s_f = ya_r;
    if (func_r == FUNC_VLINE) begin
      s_vert = 1'b1; s_a = ya_r; s_b = yb_r; s_f = xa_r;
    end else if (func_r == FUNC_RECT) begin
      case (seg_r)
        2'd0: begin s_a = xa_r; s_b = xa_r + xb_r - 18'sd1; s_f = ya_r; end
        2'd1: begin s_a = xa_r; s_b = xa_r + xb_r - 18'sd1; s_f = ya_r + yb_r - 18'sd1; end
        2'd2: begin s_vert = 1'b1; s_a = ya_r; s_b = ya_r + yb_r - 18'sd1; s_f = xa_r; end
        default: begin s_vert = 1'b1; s_a = ya_r; s_b = ya_r + yb_r - 18'sd1;
                       s_f = xa_r + xb_r - 18'sd1; end
      endcase
    end
    lim  = s_vert ? 18'(ScreenHeight) : 18'(ScreenWidth);
    s_lo = (s_a > s_b) ? s_b : s_a;
    s_hi = (s_a > s_b) ? s_a : s_b;
    if (s_lo < 0) s_lo = '0;
    if (s_hi >= lim) s_hi = lim - 18'sd1;
    s_ok = (s_f >= 0) && (s_f < (s_vert ? 18'(ScreenWidth) : 18'(ScreenHeight)))
           && (s_lo <= s_hi);
  end

  logic last_seg;
  assign last_seg = (func_r != FUNC_RECT) || (seg_r == 2'd3);

  // Glyph pixel position.
  logic [7:0]  gbits;
  logic signed [17:0] gx, gy;
  logic        g_ok;
  assign gbits = font_col(code_r, gcol_r);
  assign gx = xa_r + 18'(gcol_r);
  assign gy = ya_r + 18'(grow_r);
  assign g_ok = gbits[grow_r] && gx >= 0 && gx < ScreenWidth && gy >= 0 && gy < ScreenHeight;

  // Datapath command.
  always_comb begin
    cmd = '0;
    cmd.dot_on = on_r;
    case (state_r)
      S_DRAW: begin
        cmd.dot_en = !status.busy;
        cmd.dot_x  = vert_r ? XW'(fix_r) : XW'(cur_r);
        cmd.dot_y  = vert_r ? YW'(cur_r) : YW'(fix_r);
      end
      S_GLYPH: begin
        cmd.dot_en = g_ok && !status.busy;
        cmd.dot_on = 1'b1;
        cmd.dot_x  = XW'(gx);
        cmd.dot_y  = YW'(gy);
      end
      S_INIT, S_CLEAR: begin
        cmd.clr_en   = 1'b1;
        cmd.clr_addr = clr_r;
      end
      S_READ: begin
        cmd.rd_en   = !status.busy;
        cmd.rd_addr = AddrW'(raddr_r);
      end
      default: ;
    endcase
  end

  assign in_stall = (state_r != S_IDLE) || ovld_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    seg_nxt = seg_r;
    case (state_r)
      S_INIT:  if (clr_r == AddrW'(StoreBytes - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          case (in_func)
            FUNC_PIXEL: state_nxt = S_SEG;
            FUNC_HLINE, FUNC_VLINE, FUNC_RECT: state_nxt = S_SEG;
            FUNC_GLYPH: state_nxt = S_GLYPH;
            FUNC_CLEAR: state_nxt = S_CLEAR;
            FUNC_READ:  state_nxt = S_READ;
            default:    state_nxt = S_DONE;
          endcase
          seg_nxt = 2'd0;
        end
      end
      S_SEG: begin
        if (func_r == FUNC_RECT && !(xb_r > 0 && yb_r > 0)) state_nxt = S_DONE;
        else if (s_ok) state_nxt = S_DRAW;
        else if (last_seg) state_nxt = S_DONE;
        else seg_nxt = seg_r + 2'd1;
      end
      S_DRAW: begin
        if (!status.busy && cur_r == end_r) begin
          if (last_seg) state_nxt = S_DONE;
          else begin state_nxt = S_SEG; seg_nxt = seg_r + 2'd1; end
        end
      end
      S_GLYPH: if ((!g_ok || !status.busy) && gcol_r == 3'd4 && grow_r == 3'd6)
                 state_nxt = S_DONE;
      S_CLEAR: if (clr_r == AddrW'(StoreBytes - 1)) state_nxt = S_DONE;
      S_READ:  if (!status.busy) state_nxt = S_DONE;
      S_DONE:  if (!status.busy) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      clr_r   <= '0;
      ovld_r  <= 1'b0;
      seg_r   <= 2'd0;
    end else begin
      state_r <= state_nxt;
      seg_r   <= seg_nxt;
      if (state_r == S_INIT || state_r == S_CLEAR) clr_r <= clr_r + AddrW'(1);
      // Result register: loaded once the last write has landed.
      if (state_r == S_DONE && !status.busy) ovld_r <= 1'b1;
      else if (ovld_r && !out_stall) ovld_r <= 1'b0;
    end
  end

  // Command capture and walk counters.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid && !in_stall) begin
      func_r  <= in_func;
      xa_r    <= 18'(in_x_a);
      ya_r    <= 18'(in_y_a);
      xb_r    <= 18'(in_x_b);
      yb_r    <= 18'(in_y_b);
      on_r    <= in_color;
      code_r  <= in_char_code;
      raddr_r <= in_read_addr;
      gcol_r  <= '0;
      grow_r  <= '0;
      read_hit_r <= 1'b0;
      if (in_func == FUNC_PIXEL) begin
        // reuse the line walker: one-dot horizontal line
        func_r <= FUNC_HLINE;
        xb_r   <= 18'(in_x_a);
      end
    end
    if (state_r == S_SEG) begin
      vert_r <= s_vert;
      cur_r  <= s_lo;
      end_r  <= s_hi;
      fix_r  <= s_f;
    end
    if (state_r == S_DRAW && !status.busy) cur_r <= cur_r + 18'sd1;
    if (state_r == S_GLYPH && (!g_ok || !status.busy)) begin
      if (grow_r == 3'd6) begin
        grow_r <= '0;
        gcol_r <= gcol_r + 3'd1;
      end else grow_r <= grow_r + 3'd1;
    end
    if (state_r == S_READ && !status.busy)
      read_hit_r <= (32'(raddr_r) < StoreBytes);
    if (state_r == S_DONE && !status.busy)
      obuf_r <= read_hit_r ? status.rd_data : 8'h00;
  end

  assign out_valid     = ovld_r;
  assign out_read_data = obuf_r;

  property p_no_accept_busy;
    @(posedge clk) disable iff (!rst_n) (state_r != S_IDLE) |-> in_stall;
  endproperty
  a_no_accept_busy: assert property (p_no_accept_busy) else $error("accept while busy");

  property p_out_after_done;
    @(posedge clk) disable iff (!rst_n) $rose(ovld_r) |-> $past(state_r == S_DONE);
  endproperty
  a_out_after_done: assert property (p_out_after_done) else $error("stray result");

  property p_no_dot_in_clear;
    @(posedge clk) disable iff (!rst_n) cmd.clr_en |-> !cmd.dot_en;
  endproperty
  a_no_dot_in_clear: assert property (p_no_dot_in_clear) else $error("write conflict");
endmodule

// ===== src/mono_page_framebuffer_draw_top.sv =====
// Each command, an unused code too, gives one result on out_valid: lines and rect
// edges write one dot per step (none off screen), a glyph walks every 5x7 font cell
// and writes only set dots on screen, read-back fetches one byte, clear sweeps the store.
// Throughput: one command at a time; pixel writes are read-modify-write
// on the single-port store.
// Reset: synchronous rst_n clears all 1024 bytes of the store; no input until then.
module mono_page_framebuffer_draw_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_func,
  input  logic signed [15:0] in_x_a,
  input  logic signed [15:0] in_y_a,
  input  logic signed [15:0] in_x_b,
  input  logic signed [15:0] in_y_b,
  input  logic               in_color,
  input  logic [7:0]         in_char_code,
  input  logic [9:0]         in_read_addr,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_read_data
);
  import mpfb_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  mpfb_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_func, .in_x_a, .in_y_a, .in_x_b,
    .in_y_b, .in_color, .in_char_code, .in_read_addr, .out_valid, .out_stall,
    .out_read_data, .cmd, .status
  );

  mpfb_datapath u_dp (.clk, .cmd, .status);
endmodule

// ===== dv/tb_mono_page_framebuffer_draw_top.sv =====
// Testbench for the page framebuffer draw engine: directed and random drawing
// commands, checked against an in-bench model of the page store and read-back.
// Depends on mpfb_pkg and mono_page_framebuffer_draw_top.
module tb_mono_page_framebuffer_draw_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mpfb_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_func = '0;
  logic signed [15:0] in_x_a = '0, in_y_a = '0, in_x_b = '0, in_y_b = '0;
  logic in_color = 1'b0;
  logic [7:0] in_char_code = '0;
  logic [9:0] in_read_addr = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_read_data;

  localparam logic [2:0] FuncUnused = 3'd7;

  // Model store and queue of expected read-back bytes
  logic [7:0] page_mem [StoreBytes];
  logic [7:0] read_expq [$];
  int err_cnt = 0;

  mono_page_framebuffer_draw_top dut (.*);

  always #6 clk = ~clk;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    err_cnt++;
  endtask

  // ---- store model ----
  function automatic void plot(int x, int y, bit on);
    int idx;
    if (x < 0 || x >= ScreenWidth || y < 0 || y >= ScreenHeight) return;
    idx = x + (y / 8) * ScreenWidth;
    if (on) page_mem[idx] |= 8'(1 << (y % 8));
    else page_mem[idx] &= ~8'(1 << (y % 8));
  endfunction

  function automatic void span_row(int xa, int xb, int y, bit on);
    int t;
    if (y < 0 || y >= ScreenHeight) return;
    if (xa > xb) begin t = xa; xa = xb; xb = t; end
    if (xa < 0) xa = 0;
    if (xb >= ScreenWidth) xb = ScreenWidth - 1;
    for (int x = xa; x <= xb; x++) plot(x, y, on);
  endfunction

  function automatic void span_col(int x, int ya, int yb, bit on);
    int t;
    if (x < 0 || x >= ScreenWidth) return;
    if (ya > yb) begin t = ya; ya = yb; yb = t; end
    if (ya < 0) ya = 0;
    if (yb >= ScreenHeight) yb = ScreenHeight - 1;
    for (int y = ya; y <= yb; y++) plot(x, y, on);
  endfunction

  // Own 5x7 font, columns packed first-column-high
  function automatic logic [39:0] glyph_bits(logic [7:0] c);
    logic [39:0] d [10] = '{40'h3E514945_3E, 40'h00427F40_00, 40'h42615149_46,
      40'h2141454B_31, 40'h1814127F_10, 40'h27454545_39, 40'h3C4A4949_30,
      40'h01710905_03, 40'h36494949_36, 40'h06494929_1E};
    logic [39:0] l [26] = '{40'h7E111111_7E, 40'h7F494949_36, 40'h3E414141_22,
      40'h7F414122_1C, 40'h7F494949_41, 40'h7F090909_01, 40'h3E414949_7A,
      40'h7F080808_7F, 40'h00417F41_00, 40'h2040413F_01, 40'h7F081422_41,
      40'h7F404040_40, 40'h7F020C02_7F, 40'h7F040810_7F, 40'h3E414141_3E,
      40'h7F090909_06, 40'h3E415121_5E, 40'h7F091929_46, 40'h26494949_32,
      40'h01017F01_01, 40'h3F404040_3F, 40'h1F204020_1F, 40'h7F201820_7F,
      40'h63140814_63, 40'h07087008_07, 40'h61514945_43};
    if (c >= "0" && c <= "9") return d[c - "0"];
    if (c >= "A" && c <= "Z") return l[c - "A"];
    if (c >= "a" && c <= "z") return l[c - "a"];
    case (c)
      ".": return 40'h00606000_00;
      "-": return 40'h08080808_08;
      ":": return 40'h00363600_00;
      "/": return 40'h20100804_02;
      default: return 40'h0;
    endcase
  endfunction

  // Apply one command to the model; returns the expected read byte
  function automatic logic [7:0] apply_cmd(logic [2:0] f, int xa, int ya, int xb, int yb,
                                           bit on, logic [7:0] ch, logic [9:0] ra);
    logic [39:0] g;
    logic [7:0] colv;
    int xr, yl;
    case (f)
      FUNC_PIXEL: plot(xa, ya, on);
      FUNC_HLINE: span_row(xa, xb, ya, on);
      FUNC_VLINE: span_col(xa, ya, yb, on);
      FUNC_RECT: if (xb > 0 && yb > 0) begin
        xr = xa + xb - 1;
        yl = ya + yb - 1;
        span_row(xa, xr, ya, on);
        span_row(xa, xr, yl, on);
        span_col(xa, ya, yl, on);
        span_col(xr, ya, yl, on);
      end
      FUNC_GLYPH: begin
        g = glyph_bits(ch);
        for (int c = 0; c < 5; c++) begin
          colv = g[39 - 8*c -: 8];
          for (int r = 0; r < 7; r++) if (colv[r]) plot(xa + c, ya + r, 1'b1);
        end
      end
      FUNC_CLEAR: foreach (page_mem[i]) page_mem[i] = 8'h00;
      FUNC_READ: if (ra < StoreBytes) return page_mem[ra];
      default: ;
    endcase
    return 8'h00;
  endfunction

  // ---- send one command ----
  task automatic send_cmd(logic [2:0] f, logic signed [15:0] xa, logic signed [15:0] ya,
                          logic signed [15:0] xb, logic signed [15:0] yb, bit on,
                          logic [7:0] ch, logic [9:0] ra);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f; in_x_a <= xa; in_y_a <= ya; in_x_b <= xb; in_y_b <= yb;
    in_color <= on; in_char_code <= ch; in_read_addr <= ra;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    read_expq.push_back(apply_cmd(f, xa, ya, xb, yb, on, ch, ra));
  endtask

  task automatic read_back(logic [9:0] ra);
    send_cmd(FUNC_READ, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
             1'($urandom), 8'($urandom), ra);
  endtask

  // ---- result checker ----
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (read_expq.size() == 0) report("result with nothing expected");
      else begin
        logic [7:0] want;
        want = read_expq.pop_front();
        if (out_read_data !== want)
          report($sformatf("read_data %h, want %h", out_read_data, want));
      end
    end
  end

  // Receiver stall, redrawn each result with stall-free stretches
  initial begin
    int n;
    forever begin
      @(posedge clk);
      n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      if (n != 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!(out_valid && !out_stall)) @(posedge clk);
    end
  end

  // ---- tests ----
  task automatic test_directed();
    send_cmd(FUNC_PIXEL, 0, 0, 0, 0, 1, 0, 0);
    send_cmd(FUNC_PIXEL, 127, 63, 0, 0, 1, 0, 0);
    send_cmd(FUNC_PIXEL, -32768, 32767, 0, 0, 1, 0, 0);
    send_cmd(FUNC_HLINE, 200, -5, 3, 0, 1, 0, 0);   // reversed, clipped, row off screen
    send_cmd(FUNC_HLINE, 0, 64, 127, 0, 1, 0, 0);   // row off screen
    send_cmd(FUNC_VLINE, 5, 32767, -32768, 0, 1, 0, 0);
    send_cmd(FUNC_VLINE, 5, 10, 20, 0, 0, 0, 0);
    send_cmd(FUNC_RECT, 10, 10, 0, 5, 1, 0, 0);     // zero width
    send_cmd(FUNC_RECT, 10, 10, 5, -1, 1, 0, 0);    // negative height
    send_cmd(FUNC_RECT, -3, 60, 20, 10, 1, 0, 0);
    send_cmd(FUNC_GLYPH, 40, 20, 0, 0, 0, "a", 0);  // lowercase folds
    send_cmd(FUNC_GLYPH, 46, 20, 0, 0, 0, "/", 0);
    send_cmd(FUNC_GLYPH, 124, 60, 0, 0, 0, "8", 0); // partly off screen
    send_cmd(FUNC_GLYPH, 52, 20, 0, 0, 0, 8'hFF, 0); // unknown code
    send_cmd(FuncUnused, 0, 0, 0, 0, 1, 0, 0);
    for (int i = 0; i < 4; i++) read_back(10'(i * 130 + 10));
    read_back(10'd1023);
    read_back(10'd0);
    send_cmd(FUNC_CLEAR, 0, 0, 0, 0, 0, 0, 0);
    read_back(10'd0);
  endtask

  function automatic logic signed [15:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return 16'($urandom);
      1: return -$signed(16'($urandom_range(0, 20)));
      default: return 16'($urandom_range(0, 140));
    endcase
  endfunction

  task automatic test_random(int n);
    logic [2:0] f;
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) f = FUNC_READ;
      else if (pick < 31) f = FUNC_CLEAR;
      else if (pick < 32) f = FuncUnused;
      else f = 3'($urandom_range(0, 4));
      send_cmd(f, rand_coord(), rand_coord(),
               (f == FUNC_RECT && $urandom_range(0, 3) != 0) ?
                 16'($urandom_range(0, 40)) : rand_coord(),
               (f == FUNC_RECT && $urandom_range(0, 3) != 0) ?
                 16'($urandom_range(0, 20)) : rand_coord(),
               1'($urandom),
               ($urandom_range(0, 1)) ? 8'($urandom_range(8'h20, 8'h7A)) : 8'($urandom),
               10'($urandom));
    end
  endtask

  // ---- main sequence ----
  initial begin
    int waitc;
    foreach (page_mem[i]) page_mem[i] = 8'h00;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(1600);
    in_valid <= 1'b0;
    waitc = 0;
    while (read_expq.size() != 0 && waitc < 200000) begin
      @(posedge clk);
      waitc++;
    end
    repeat (50) @(posedge clk);
    if (err_cnt == 0 && read_expq.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  // Watchdog
  initial begin
    #200ms;
    $display("simulation failed");
    $finish;
  end
endmodule
